>>> rtl/core/ets_pkg.sv
// ----------------------------------------------------------------------------
// ets_pkg
// Types, constants and calendar helpers for the epoch seconds converter.
// ----------------------------------------------------------------------------
package ets_pkg;

  localparam int unsigned AccW   = 32;
  localparam int unsigned QuotW  = 16;
  localparam int unsigned RemW   = 17;
  localparam int unsigned CntW   = 4;
  localparam int unsigned YearW  = 12;
  localparam int unsigned LenW   = 9;

  localparam logic [AccW-1:0]  SecsPerMin  = AccW'(60);
  localparam logic [AccW-1:0]  SecsPerHour = AccW'(60 * 60);
  localparam logic [AccW-1:0]  SecsPerDay  = AccW'(24 * 60 * 60);
  localparam logic [YearW-1:0] EpochYear   = YearW'(1970);
  localparam logic [LenW-1:0]  DaysLeap    = LenW'(366);
  localparam logic [LenW-1:0]  DaysCommon  = LenW'(365);

  localparam logic [CntW-1:0]  DayQuotMsb  = CntW'(QuotW - 1);
  localparam logic [CntW-1:0]  HourQuotMsb = CntW'(4);
  localparam logic [CntW-1:0]  MinQuotMsb  = CntW'(5);

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthDec = 4'd12;

  typedef struct packed {
    logic [31:0] epoch_seconds;
  } ets_req_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } ets_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAYS,
    ST_YEAR,
    ST_MONTH,
    ST_HOUR,
    ST_MIN,
    ST_DONE
  } ets_state_e;

  // 2000 and 2100 are the only century years reachable from a 32-bit count.
  function automatic logic leap_year(input logic [YearW-1:0] y);
    return (y[1:0] == 2'b00) && (y != YearW'(2100));
  endfunction

  function automatic logic [LenW-1:0] days_before_month(input logic lp,
                                                        input logic [3:0] m);
    logic [LenW-1:0] d;
    unique case (m)
      4'd2:    d = LenW'(31);
      4'd3:    d = lp ? LenW'(60)  : LenW'(59);
      4'd4:    d = lp ? LenW'(91)  : LenW'(90);
      4'd5:    d = lp ? LenW'(121) : LenW'(120);
      4'd6:    d = lp ? LenW'(152) : LenW'(151);
      4'd7:    d = lp ? LenW'(182) : LenW'(181);
      4'd8:    d = lp ? LenW'(213) : LenW'(212);
      4'd9:    d = lp ? LenW'(244) : LenW'(243);
      4'd10:   d = lp ? LenW'(274) : LenW'(273);
      4'd11:   d = lp ? LenW'(305) : LenW'(304);
      4'd12:   d = lp ? LenW'(335) : LenW'(334);
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/core/ets_req_if.sv
// ----------------------------------------------------------------------------
// ets_req_if
// Request channel carrying one epoch seconds count.
// ----------------------------------------------------------------------------
interface ets_req_if;
  logic              valid;
  logic              ready;
  ets_pkg::ets_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/ets_rsp_if.sv
// ----------------------------------------------------------------------------
// ets_rsp_if
// Response channel carrying one calendar date and time of day.
// ----------------------------------------------------------------------------
interface ets_rsp_if;
  logic              valid;
  logic              ready;
  ets_pkg::ets_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/ets_sub_unit.sv
// ----------------------------------------------------------------------------
// ets_sub_unit
// Shared subtract and compare unit: difference and borrow of two operands.
// ----------------------------------------------------------------------------
module ets_sub_unit (
  input  logic [ets_pkg::AccW-1:0] opa_i,
  input  logic [ets_pkg::AccW-1:0] opb_i,
  output logic [ets_pkg::AccW-1:0] diff_o,
  output logic                     borrow_o
);
  import ets_pkg::*;

  logic [AccW:0] full;

  assign full     = {1'b0, opa_i} - {1'b0, opb_i};
  assign diff_o   = full[AccW-1:0];
  assign borrow_o = full[AccW];

endmodule

>>> rtl/core/epoch_seconds_to_calendar_top.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Converts seconds since 1970-01-01 00:00:00 into calendar date and time.
// ----------------------------------------------------------------------------
// Sequence: from request to response the shared subtractor runs 16 day-division
//   steps, one step per year walked, up to 12 month steps, 5 hour steps,
//   6 minute steps and then the unload into the output register.
// Throughput: one request at a time; the next is taken once the result sits
//   in the output register.
// Reset: asynchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  ets_req_if.sink   req_i,
  ets_rsp_if.source rsp_o
);
  import ets_pkg::*;

  ets_state_e       state_q, state_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [QuotW-1:0] quot_q, quot_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [YearW-1:0] year_q, year_d;
  logic [3:0]       month_q, month_d;
  logic [4:0]       day_q, day_d;
  logic [4:0]       hour_q, hour_d;
  logic [5:0]       minute_q, minute_d;
  logic [5:0]       second_q, second_d;
  logic             out_vld_q, out_vld_d;
  ets_rsp_t         out_q, out_d;

  logic [AccW-1:0]  opb;
  logic [AccW-1:0]  diff;
  logic             borrow;
  logic [AccW-1:0]  acc_sel;
  logic [QuotW-1:0] quot_sh;
  logic             lp;
  logic             req_acc;
  logic             unload;

  assign lp      = leap_year(year_q);
  assign req_acc = req_i.valid && req_i.ready;
  assign unload  = (state_q == ST_DONE) && (!out_vld_q || rsp_o.ready);
  assign acc_sel = borrow ? acc_q : diff;
  assign quot_sh = {quot_q[QuotW-2:0], ~borrow};

  always_comb begin
    unique case (state_q)
      ST_DAYS:  opb = SecsPerDay << cnt_q;
      ST_YEAR:  opb = AccW'(lp ? DaysLeap : DaysCommon);
      ST_MONTH: opb = AccW'(days_before_month(lp, month_q));
      ST_HOUR:  opb = SecsPerHour << cnt_q;
      ST_MIN:   opb = SecsPerMin << cnt_q;
      default:  opb = '0;
    endcase
  end

  ets_sub_unit u_sub (
    .opa_i    (acc_q),
    .opb_i    (opb),
    .diff_o   (diff),
    .borrow_o (borrow)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (req_acc) state_d = ST_DAYS;
      ST_DAYS:  if (cnt_q == '0) state_d = ST_YEAR;
      ST_YEAR:  if (borrow) state_d = ST_MONTH;
      ST_MONTH: if (!borrow) state_d = ST_HOUR;
      ST_HOUR:  if (cnt_q == '0) state_d = ST_MIN;
      ST_MIN:   if (cnt_q == '0) state_d = ST_DONE;
      ST_DONE:  if (unload) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    acc_d    = acc_q;
    quot_d   = quot_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    out_d    = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          acc_d  = req_i.payload.epoch_seconds;
          quot_d = '0;
          cnt_d  = DayQuotMsb;
        end
      end
      ST_DAYS: begin
        quot_d = quot_sh;
        cnt_d  = cnt_q - 1'b1;
        acc_d  = acc_sel;
        if (cnt_q == '0) begin
          rem_d  = acc_sel[RemW-1:0];
          acc_d  = AccW'(quot_sh);
          year_d = EpochYear;
        end
      end
      ST_YEAR: begin
        if (!borrow) begin
          acc_d  = diff;
          year_d = year_q + 1'b1;
        end else begin
          month_d = MonthDec;
        end
      end
      ST_MONTH: begin
        if (borrow) begin
          month_d = month_q - 1'b1;
        end else begin
          day_d  = diff[4:0] + 5'd1;
          acc_d  = AccW'(rem_q);
          quot_d = '0;
          cnt_d  = HourQuotMsb;
        end
      end
      ST_HOUR: begin
        quot_d = quot_sh;
        cnt_d  = cnt_q - 1'b1;
        acc_d  = acc_sel;
        if (cnt_q == '0) begin
          hour_d = quot_sh[4:0];
          quot_d = '0;
          cnt_d  = MinQuotMsb;
        end
      end
      ST_MIN: begin
        quot_d = quot_sh;
        cnt_d  = cnt_q - 1'b1;
        acc_d  = acc_sel;
        if (cnt_q == '0) begin
          minute_d = quot_sh[5:0];
          second_d = acc_sel[5:0];
        end
      end
      ST_DONE: begin
        if (unload) begin
          out_d.year   = year_q;
          out_d.month  = month_q;
          out_d.day    = day_q;
          out_d.hour   = hour_q;
          out_d.minute = minute_q;
          out_d.second = second_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (unload) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    quot_q   <= quot_d;
    cnt_q    <= cnt_d;
    rem_q    <= rem_d;
    year_q   <= year_d;
    month_q  <= month_d;
    day_q    <= day_d;
    hour_q   <= hour_d;
    minute_q <= minute_d;
    second_q <= second_d;
    out_q    <= out_d;
  end

  assign req_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.payload = out_q;

  a_accept_starts_days: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> state_q == ST_DAYS)
    else $error("request accepted without starting the day division");

  a_year_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_YEAR |-> year_q <= YearW'(2106))
    else $error("year walk ran past the representable range");

  a_month_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MONTH |-> (month_q >= MonthJan) && (month_q <= MonthDec))
    else $error("month search left January to December");

  a_hour_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOUR |-> acc_q < SecsPerDay)
    else $error("time of day remainder exceeds one day");

  a_unload_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unload |=> out_vld_q && (state_q == ST_IDLE))
    else $error("result unload did not present a response");

endmodule
